// ===== sv/pcm_to_stereo16_upsampler_top_assert.svh =====
// Assertion macros for the PCM upsampler RTL, used by the result register.
`ifndef PCM_TO_STEREO16_UPSAMPLER_TOP_ASSERT_SVH
`define PCM_TO_STEREO16_UPSAMPLER_TOP_ASSERT_SVH

// A property checked on every rising clock edge outside reset.
`define PCMUP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A same-cycle implication checked outside reset.
`define PCMUP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A next-cycle implication checked outside reset.
`define PCMUP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pcmup_pkg.sv =====
// Shared types and constants of the PCM to 16-bit stereo upsampler.
package pcmup_pkg;

  localparam int MAX_REPEAT = 16;
  localparam int CNT_W      = $clog2(MAX_REPEAT + 1);
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_MODE     = 3'd0,
    REG_TWO_CHANNELS  = 3'd1,
    REG_WIDE_SAMPLES  = 3'd2,
    REG_REPEAT_FACTOR = 3'd3,
    REG_TONE_STEP     = 3'd4,
    REG_TONE_PEAK     = 3'd5,
    REG_TONE_LENGTH   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        tone_mode;
    logic        two_channels;
    logic        wide_samples;
    logic [4:0]  repeat_factor;
    logic [14:0] tone_step;
    logic [14:0] tone_peak;
    logic [23:0] tone_length;
    logic        tone_restart;  // pulse: tone_length written this cycle
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               tone_done;
  } result_t;

endpackage

// ===== sv/pcmup_cfg.sv =====
// Configuration register bank of the PCM upsampler.
module pcmup_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcmup_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcmup_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output pcmup_pkg::cfg_t                 cfg_o
);

  pcmup_pkg::cfg_idx_e idx;
  logic        tone_mode_q, two_channels_q, wide_samples_q;
  logic [4:0]  repeat_factor_q;
  logic [14:0] tone_step_q, tone_peak_q;
  logic [23:0] tone_length_q;
  logic        restart;

  assign idx     = pcmup_pkg::cfg_idx_e'(cfg_idx_i);
  assign restart = cfg_we_i && (idx == pcmup_pkg::REG_TONE_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_mode_q     <= 1'b0;
      two_channels_q  <= 1'b1;
      wide_samples_q  <= 1'b1;
      repeat_factor_q <= 5'd1;
      tone_step_q     <= '0;
      tone_peak_q     <= '0;
      tone_length_q   <= '0;
    end else if (cfg_we_i) begin
      case (idx)
        pcmup_pkg::REG_TONE_MODE:     tone_mode_q     <= cfg_wdata_i[0];
        pcmup_pkg::REG_TWO_CHANNELS:  two_channels_q  <= cfg_wdata_i[0];
        pcmup_pkg::REG_WIDE_SAMPLES:  wide_samples_q  <= cfg_wdata_i[0];
        pcmup_pkg::REG_REPEAT_FACTOR: repeat_factor_q <= cfg_wdata_i[4:0];
        pcmup_pkg::REG_TONE_STEP:     tone_step_q     <= cfg_wdata_i[14:0];
        pcmup_pkg::REG_TONE_PEAK:     tone_peak_q     <= cfg_wdata_i[14:0];
        pcmup_pkg::REG_TONE_LENGTH:   tone_length_q   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.tone_mode     = tone_mode_q;
    cfg_o.two_channels  = two_channels_q;
    cfg_o.wide_samples  = wide_samples_q;
    cfg_o.repeat_factor = repeat_factor_q;
    cfg_o.tone_step     = tone_step_q;
    cfg_o.tone_peak     = tone_peak_q;
    // During a length write the new value goes straight to the tone
    // generator, so the restart loads the length being written.
    cfg_o.tone_length   = restart ? cfg_wdata_i[23:0] : tone_length_q;
    cfg_o.tone_restart  = restart;
  end

endmodule

// ===== sv/pcmup_frame.sv =====
// Byte assembly and triangle tone generation for the PCM upsampler.
module pcmup_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcmup_pkg::cfg_t             cfg_i,
  input  logic                        accept_i,
  input  logic [7:0]                  data_byte_i,
  output logic                        produces_o,
  output pcmup_pkg::result_t          result_o,
  output logic [pcmup_pkg::CNT_W-1:0] reps_o
);

  logic [23:0]        held_q, held_d;
  logic [1:0]         phase_q, phase_d;
  logic signed [15:0] level_q, level_d;
  logic               falling_q, falling_d;
  logic [23:0]        remain_q, remain_d;

  logic [2:0]          frame_sz;
  logic                complete;
  logic signed [17:0]  lvl_ext, step_ext, peak_ext, next_raw, next_sat;

  always_comb begin
    case ({cfg_i.wide_samples, cfg_i.two_channels})
      2'b11:   frame_sz = 3'd4;
      2'b10:   frame_sz = 3'd2;
      2'b01:   frame_sz = 3'd2;
      default: frame_sz = 3'd1;
    endcase
  end

  assign complete   = ({1'b0, phase_q} + 3'd1) >= frame_sz;
  assign produces_o = cfg_i.tone_mode || complete;

  // Triangle arithmetic, kept in 18 bits so the step never wraps.
  assign lvl_ext  = 18'(level_q);
  assign step_ext = $signed({3'b000, cfg_i.tone_step});
  assign peak_ext = $signed({3'b000, cfg_i.tone_peak});
  assign next_raw = falling_q ? (lvl_ext - step_ext) : (lvl_ext + step_ext);

  always_comb begin
    if (next_raw > 18'sd32767) begin
      next_sat = 18'sd32767;
    end else if (next_raw < -18'sd32767) begin
      next_sat = -18'sd32767;
    end else begin
      next_sat = next_raw;
    end
  end

  always_comb begin
    result_o = '0;
    reps_o   = pcmup_pkg::CNT_W'(1);
    if (cfg_i.tone_mode) begin
      if (remain_q == '0) begin
        result_o.tone_done = 1'b1;
      end else begin
        result_o.left_sample  = level_q;
        result_o.right_sample = level_q;
      end
    end else begin
      case ({cfg_i.wide_samples, cfg_i.two_channels})
        2'b11: begin
          result_o.left_sample  = {held_q[15:8], held_q[23:16]};
          result_o.right_sample = {data_byte_i, held_q[7:0]};
        end
        2'b10: begin
          result_o.left_sample  = {data_byte_i, held_q[7:0]};
          result_o.right_sample = {data_byte_i, held_q[7:0]};
        end
        2'b01: begin
          result_o.left_sample  = {~held_q[7], held_q[6:0], 8'h00};
          result_o.right_sample = {~data_byte_i[7], data_byte_i[6:0], 8'h00};
        end
        default: begin
          result_o.left_sample  = {~data_byte_i[7], data_byte_i[6:0], 8'h00};
          result_o.right_sample = {~data_byte_i[7], data_byte_i[6:0], 8'h00};
        end
      endcase
      // Repeat count is clamped to one through the maximum.
      if (cfg_i.repeat_factor == 5'd0) begin
        reps_o = pcmup_pkg::CNT_W'(1);
      end else if (32'(cfg_i.repeat_factor) > 32'(pcmup_pkg::MAX_REPEAT)) begin
        reps_o = pcmup_pkg::CNT_W'(pcmup_pkg::MAX_REPEAT);
      end else begin
        reps_o = pcmup_pkg::CNT_W'(cfg_i.repeat_factor);
      end
    end
  end

  always_comb begin
    held_d    = held_q;
    phase_d   = phase_q;
    level_d   = level_q;
    falling_d = falling_q;
    remain_d  = remain_q;
    if (cfg_i.tone_restart) begin
      remain_d  = cfg_i.tone_length;
      level_d   = '0;
      falling_d = 1'b0;
    end else if (accept_i) begin
      if (cfg_i.tone_mode) begin
        if (remain_q != '0) begin
          remain_d = remain_q - 24'd1;
          level_d  = next_sat[15:0];
          if ((next_sat >= peak_ext) || (next_sat <= -peak_ext)) begin
            falling_d = ~falling_q;
          end
        end
      end else begin
        held_d  = {held_q[15:0], data_byte_i};
        phase_d = complete ? 2'd0 : (phase_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      phase_q   <= '0;
      level_q   <= '0;
      falling_q <= 1'b0;
      remain_q  <= '0;
    end else begin
      held_q    <= held_d;
      phase_q   <= phase_d;
      level_q   <= level_d;
      falling_q <= falling_d;
      remain_q  <= remain_d;
    end
  end

endmodule

// ===== sv/pcmup_out.sv =====
// Result register with repeat counter for the PCM upsampler.
`include "pcm_to_stereo16_upsampler_top_assert.svh"

module pcmup_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  pcmup_pkg::result_t          result_i,
  input  logic [pcmup_pkg::CNT_W-1:0] reps_i,
  output logic                        can_load_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic signed [15:0]          left_sample_o,
  output logic signed [15:0]          right_sample_o,
  output logic                        last_copy_o,
  output logic                        tone_done_o
);

  logic                        valid_q;
  logic [pcmup_pkg::CNT_W-1:0] cnt_q;
  pcmup_pkg::result_t          data_q;
  logic                        last;
  logic                        take;

  assign last       = (cnt_q == pcmup_pkg::CNT_W'(1));
  assign take       = valid_q && out_ready_i;
  assign can_load_o = !valid_q || (take && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= reps_i;
    end else if (take) begin
      if (last) begin
        valid_q <= 1'b0;
      end
      cnt_q <= cnt_q - pcmup_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign left_sample_o  = data_q.left_sample;
  assign right_sample_o = data_q.right_sample;
  assign last_copy_o    = last;
  assign tone_done_o    = data_q.tone_done;

  `PCMUP_ASSERT_IMP(a_cnt_nonzero, valid_q, cnt_q != '0, "valid result with zero copies left")
  `PCMUP_ASSERT_IMP(a_no_overwrite, load_i, can_load_o, "new frame loaded over pending copies")
  `PCMUP_ASSERT_NXT(a_next_copy, take && !last, valid_q && (cnt_q == $past(cnt_q) - 1'b1), "repeat copy lost")
  `PCMUP_ASSERT(a_load_reps, !load_i || (reps_i != '0), "frame loaded with zero copies")

endmodule

// ===== sv/pcm_to_stereo16_upsampler_top.sv =====
// Top level of the PCM byte stream to 16-bit stereo upsampler.
//
//  Channel  Direction  Handshake                    Payload
//  in       sink       in_valid_i / in_ready_o      data_byte_i
//  out      source     out_valid_o / out_ready_i    left/right_sample_o, last_copy_o, tone_done_o
//  cfg      sink       cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// Every item passes through combinational logic from the byte assembly registers
// into the result register. A byte that only fills a frame is taken every cycle,
// even while a result waits. A byte that completes a frame, or a tone tick, is
// taken when the result register is empty or its last copy is being taken.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the frame phase, the held bytes and the tone state.
module pcm_to_stereo16_upsampler_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [15:0]                left_sample_o,
  output logic signed [15:0]                right_sample_o,
  output logic                              last_copy_o,
  output logic                              tone_done_o,
  input  logic                              cfg_we_i,
  input  logic [pcmup_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcmup_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  pcmup_pkg::cfg_t             cfg;
  pcmup_pkg::result_t          result;
  logic [pcmup_pkg::CNT_W-1:0] reps;
  logic                        produces;
  logic                        can_load;
  logic                        accept;

  // Bytes that produce no result never need the output register, so they
  // flow in regardless of output back-pressure.
  assign in_ready_o = !produces || can_load;
  assign accept     = in_valid_i && in_ready_o;

  pcmup_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pcmup_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .produces_o  (produces),
    .result_o    (result),
    .reps_o      (reps)
  );

  // The result register holds one frame and replays it for every copy.
  pcmup_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept && produces),
    .result_i       (result),
    .reps_i         (reps),
    .can_load_o     (can_load),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .last_copy_o    (last_copy_o),
    .tone_done_o    (tone_done_o)
  );

endmodule
